>>> rtl/mesh_vertex_store_face_normal_defines.svh
// ----------------------------------------------------------------------------
// Mesh vertex store assertion macros
// Shared concurrent assertion forms for the face normal block.
// ----------------------------------------------------------------------------
`ifndef MESH_VERTEX_STORE_FACE_NORMAL_DEFINES_SVH
`define MESH_VERTEX_STORE_FACE_NORMAL_DEFINES_SVH

// implication checked every clock edge outside reset
`define MVS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/mvsfn_pkg.sv
// ----------------------------------------------------------------------------
// mvsfn_pkg
// Constants and command/status types for the mesh vertex store.
// ----------------------------------------------------------------------------
package mvsfn_pkg;

    localparam int MaxTriangles = 16;
    localparam int Entries      = MaxTriangles * 3;
    localparam int EntW         = $clog2(Entries);
    localparam int TriW         = 4;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_SCALE   = 2'd1;
    localparam logic [1:0] FUNC_NORMAL  = 2'd2;
    localparam logic [1:0] FUNC_READ    = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_RDPOS,
        OP_LOAD0,
        OP_LOAD1,
        OP_LOAD2,
        OP_SCALE_MUL,
        OP_SCALE_FIN,
        OP_CROSS,
        OP_CROSS_SUM,
        OP_NORM_PREP,
        OP_SQUARE,
        OP_SQRT,
        OP_DIV,
        OP_WNORM,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [1:0]       idx;
        logic [EntW-1:0]  entry;
        logic             zero_out;
    } cmd_t;

    typedef struct packed {
        logic       done;
        logic       degen;
    } stat_t;

endpackage

>>> rtl/mesh_vertex_store_face_normal.sv
// ----------------------------------------------------------------------------
// mesh_vertex_store_face_normal
// Triangle corner store with height scaling and face normal recompute.
//
// channel  | handshake     | words
// command  | start / busy  | func, triangle_index, corner, coord_x/y/z, scale_factor
// result   | valid strobe  | pos_x/y/z, normal_x/y/z, degenerate
//
// One command at a time; busy stays high until its result strobe.
// Read, write and scale end with a corner read-out; scale uses one 17x17 multiply.
// Normal: the normalizing shift (up to 29 steps), the bit-serial sqrt
// (31 steps) and three restoring divides, one per normal lane;
// a zero cross product skips the sqrt and divides. Out of range address: zeroed result.
// Reset clears the controller and the datapath valid and mode flags; corner memories are not cleared.
// The result is a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module mesh_vertex_store_face_normal (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           func,
    input  logic [3:0]           triangle_index,
    input  logic [1:0]           corner,
    input  logic signed [15:0]   coord_x,
    input  logic signed [15:0]   coord_y,
    input  logic signed [15:0]   coord_z,
    input  logic [15:0]          scale_factor,
    output logic                 valid,
    output logic signed [15:0]   pos_x,
    output logic signed [15:0]   pos_y,
    output logic signed [15:0]   pos_z,
    output logic signed [15:0]   normal_x,
    output logic signed [15:0]   normal_y,
    output logic signed [15:0]   normal_z,
    output logic                 degenerate
);
    import mvsfn_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mvsfn_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .func(func),
        .triangle_index(triangle_index), .corner(corner),
        .busy(busy), .cmd(cmd), .stat(stat)
    );

    mvsfn_dp u_dp (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .scale_factor(scale_factor), .cmd(cmd), .stat(stat), .valid(valid),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .degenerate(degenerate)
    );

endmodule

>>> rtl/mvsfn_ctrl.sv
// ----------------------------------------------------------------------------
// mvsfn_ctrl
// Sequencer: walks each command through its datapath steps.
// ----------------------------------------------------------------------------
`include "mesh_vertex_store_face_normal_defines.svh"
module mvsfn_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           func,
    input  logic [3:0]           triangle_index,
    input  logic [1:0]           corner,
    output logic                 busy,
    output mvsfn_pkg::cmd_t      cmd,
    input  mvsfn_pkg::stat_t     stat
);
    import mvsfn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_WR, S_SC1, S_SC2, S_L0, S_L1, S_L2, S_CR, S_CS, S_NP,
        S_SQ, S_RT, S_DV, S_WN, S_RP, S_RES
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      fn_reg, fn_next;
    logic [EntW-1:0] ent_reg, ent_next;
    logic [EntW-1:0] base_reg, base_next;
    logic            oob_reg, oob_next;
    logic [1:0]      wn_reg, wn_next;
    logic            acc;
    logic [EntW+1:0] ent_w;

    assign acc   = start && !busy;
    assign busy  = state_reg != S_IDLE;
    assign ent_w = (EntW+2)'(triangle_index) * (EntW+2)'(3) + (EntW+2)'(corner);

    always_comb
    begin
        state_next = state_reg;
        fn_next    = fn_reg;
        ent_next   = ent_reg;
        base_next  = base_reg;
        oob_next   = oob_reg;
        wn_next    = wn_reg;
        cmd        = '{op: OP_NONE, idx: 2'd0, entry: ent_reg, zero_out: oob_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    fn_next   = func;
                    oob_next  = (32'(triangle_index) >= MaxTriangles) || (corner == 2'd3);
                    ent_next  = ent_w[EntW-1:0];
                    base_next = EntW'((EntW+2)'(triangle_index) * (EntW+2)'(3));
                    wn_next   = 2'd0;
                    if ((32'(triangle_index) >= MaxTriangles) || (corner == 2'd3))
                        state_next = S_RP;
                    else
                    begin
                        case (func)
                            FUNC_WRITE:  state_next = S_WR;
                            FUNC_SCALE:  state_next = S_SC1;
                            FUNC_NORMAL: state_next = S_L0;
                            default:     state_next = S_RP;
                        endcase
                    end
                end
            end
            S_WR:
            begin
                cmd.op = OP_WRITE;
                state_next = S_RP;
            end
            S_SC1:
            begin
                cmd.op = OP_RDPOS;
                state_next = S_SC2;
            end
            S_SC2:
            begin
                cmd.op = OP_SCALE_MUL;
                state_next = S_WN;
            end
            S_L0:
            begin
                cmd.op = OP_LOAD0;
                cmd.entry = base_reg;
                state_next = S_L1;
            end
            S_L1:
            begin
                cmd.op = OP_LOAD1;
                cmd.entry = base_reg + EntW'(1);
                state_next = S_L2;
            end
            S_L2:
            begin
                cmd.op = OP_LOAD2;
                cmd.entry = base_reg + EntW'(2);
                state_next = S_CR;
            end
            S_CR:
            begin
                cmd.op = OP_CROSS;
                state_next = S_CS;
            end
            S_CS:
            begin
                cmd.op = OP_CROSS_SUM;
                state_next = S_NP;
            end
            S_NP:
            begin
                cmd.op = OP_NORM_PREP;
                if (!stat.done)
                    state_next = S_NP;
                else
                    state_next = stat.degen ? S_WN : S_SQ;
            end
            S_SQ:
            begin
                cmd.op = OP_SQUARE;
                state_next = S_RT;
            end
            S_RT:
            begin
                cmd.op = OP_SQRT;
                if (stat.done)
                    state_next = S_DV;
            end
            S_DV:
            begin
                cmd.op = OP_DIV;
                if (stat.done)
                    state_next = S_WN;
            end
            S_WN:
            begin
                if (fn_reg == FUNC_SCALE)
                begin
                    cmd.op = OP_SCALE_FIN;
                    state_next = S_RP;
                end
                else
                begin
                    cmd.op = OP_WNORM;
                    cmd.entry = base_reg + EntW'(wn_reg);
                    wn_next = wn_reg + 2'd1;
                    if (wn_reg == 2'd2)
                        state_next = S_RP;
                end
            end
            S_RP:
            begin
                cmd.op = OP_RDPOS;
                state_next = S_RES;
            end
            S_RES:
            begin
                cmd.op = OP_RESULT;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fn_reg    <= FUNC_WRITE;
            ent_reg   <= '0;
            base_reg  <= '0;
            oob_reg   <= 1'b0;
            wn_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            fn_reg    <= fn_next;
            ent_reg   <= ent_next;
            base_reg  <= base_next;
            oob_reg   <= oob_next;
            wn_reg    <= wn_next;
        end
    end

    `MVS_ASSERT_NEXT(a_accept_busy, acc, busy)
    `MVS_ASSERT_NEXT(a_res_idle, state_reg == S_RES, state_reg == S_IDLE)
    `MVS_ASSERT_IMPL(a_wn_range, state_reg == S_WN && fn_reg != FUNC_SCALE, wn_reg != 2'd3)

endmodule

>>> rtl/mvsfn_dp.sv
// ----------------------------------------------------------------------------
// mvsfn_dp
// Datapath: corner memories, scale, cross product, sqrt and divide units.
// ----------------------------------------------------------------------------
module mvsfn_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic signed [15:0]   coord_x,
    input  logic signed [15:0]   coord_y,
    input  logic signed [15:0]   coord_z,
    input  logic [15:0]          scale_factor,
    input  mvsfn_pkg::cmd_t      cmd,
    output mvsfn_pkg::stat_t     stat,
    output logic                 valid,
    output logic signed [15:0]   pos_x,
    output logic signed [15:0]   pos_y,
    output logic signed [15:0]   pos_z,
    output logic signed [15:0]   normal_x,
    output logic signed [15:0]   normal_y,
    output logic signed [15:0]   normal_z,
    output logic                 degenerate
);
    import mvsfn_pkg::*;

    logic [47:0] pos_mem [Entries];
    logic [47:0] nrm_mem [Entries];
    logic [47:0] prd_reg, nrd_reg;

    logic signed [15:0] cx_reg, cy_reg, cz_reg;
    logic [15:0]        fac_reg;
    logic signed [15:0] v0_reg [3];
    logic signed [16:0] a_reg [3];
    logic signed [16:0] b_reg [3];
    logic signed [34:0] p_reg [6];
    logic        [35:0] m_reg [3];
    logic               sgn_reg [3];
    logic               degen_reg;
    logic        [61:0] sum_reg;
    logic        [61:0] rem_reg;
    logic        [30:0] root_reg;
    logic        [4:0]  cnt_reg;
    logic        [1:0]  lane_reg;
    logic        [45:0] dnum_reg;
    logic        [13:0] dq_reg;
    logic        [5:0]  dcnt_reg;
    logic signed [15:0] nv_reg [3];
    logic signed [33:0] sp_reg;
    logic               out_v_reg;
    logic signed [15:0] o_reg [6];
    logic               o_deg_reg;
    logic               np_done;
    logic               c_valid_deg;
    logic               func_norm_reg;

    logic signed [16:0] ycur;
    logic signed [33:0] q;
    logic signed [21:0] r;
    logic signed [22:0] ry;
    logic        [35:0] mx;
    logic        [32:0] trial;
    logic        [61:0] rem_sh;
    logic        [31:0] dtrial;
    logic        [45:0] dsum;
    logic        [61:0] sq;

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cx_reg  <= coord_x;
            cy_reg  <= coord_y;
            cz_reg  <= coord_z;
            fac_reg <= scale_factor;
        end
        if (cmd.op == OP_WRITE)
            pos_mem[cmd.entry] <= {cz_reg, cy_reg, cx_reg};
        if (cmd.op == OP_SCALE_FIN)
            pos_mem[cmd.entry] <= {prd_reg[47:32], ry[15:0], prd_reg[15:0]};
        if (cmd.op == OP_WNORM)
            nrm_mem[cmd.entry] <= degen_reg ? 48'd0 : {nv_reg[2], nv_reg[1], nv_reg[0]};
        prd_reg <= pos_mem[cmd.entry];
        nrd_reg <= nrm_mem[cmd.entry];
    end

    assign ycur = 17'(signed'(prd_reg[31:16])) + 17'sd4096;
    assign q    = sp_reg + 34'sd2048;
    assign r    = 22'(q >>> 12);
    always_comb
    begin
        if (r > 22'sd36863)
            ry = 23'sd32767;
        else if (r < -22'sd28672)
            ry = -23'sd32768;
        else
            ry = 23'(r) - 23'sd4096;
    end

    always_comb
    begin
        mx = m_reg[0];
        if (m_reg[1] > mx) mx = m_reg[1];
        if (m_reg[2] > mx) mx = m_reg[2];
    end
    assign np_done = (mx == 36'd0) || (mx[35:29] == 7'd1);
    assign stat.done = (cmd.op == OP_NORM_PREP) ? (np_done && cnt_reg != 5'd0) :
                       (cmd.op == OP_SQRT) ? (cnt_reg == 5'd30) :
                       (cmd.op == OP_DIV) ? (lane_reg == 2'd2 && dcnt_reg == 6'd15) : 1'b0;
    assign stat.degen = (mx == 36'd0);

    assign rem_sh = {rem_reg[59:0], sum_reg[61:60]};
    assign trial  = {root_reg[30:0], 2'b01};
    assign sq     = 62'(m_reg[0][29:0] * m_reg[0][29:0]) + 62'(m_reg[1][29:0] * m_reg[1][29:0])
                  + 62'(m_reg[2][29:0] * m_reg[2][29:0]);
    assign dtrial = dnum_reg[45:14] - 32'({1'b0, root_reg});
    assign dsum   = 46'(m_reg[lane_reg][29:0]) << 14;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_SCALE_MUL:
            begin
                sp_reg <= 34'(signed'(ycur)) * 34'(signed'({1'b0, fac_reg}));
            end
            OP_LOAD1:
            begin
                v0_reg[0] <= signed'(prd_reg[15:0]);
                v0_reg[1] <= signed'(prd_reg[31:16]);
                v0_reg[2] <= signed'(prd_reg[47:32]);
            end
            OP_LOAD2:
            begin
                a_reg[0] <= 17'(signed'(prd_reg[15:0])) - 17'(v0_reg[0]);
                a_reg[1] <= 17'(signed'(prd_reg[31:16])) - 17'(v0_reg[1]);
                a_reg[2] <= 17'(signed'(prd_reg[47:32])) - 17'(v0_reg[2]);
            end
            OP_CROSS:
            begin
                b_reg[0] <= 17'(signed'(prd_reg[15:0])) - 17'(v0_reg[0]);
                b_reg[1] <= 17'(signed'(prd_reg[31:16])) - 17'(v0_reg[1]);
                b_reg[2] <= 17'(signed'(prd_reg[47:32])) - 17'(v0_reg[2]);
            end
            OP_CROSS_SUM:
            begin
                p_reg[0] <= 35'(a_reg[1] * b_reg[2]);
                p_reg[1] <= 35'(a_reg[2] * b_reg[1]);
                p_reg[2] <= 35'(a_reg[2] * b_reg[0]);
                p_reg[3] <= 35'(a_reg[0] * b_reg[2]);
                p_reg[4] <= 35'(a_reg[0] * b_reg[1]);
                p_reg[5] <= 35'(a_reg[1] * b_reg[0]);
                cnt_reg  <= 5'd0;
            end
            OP_NORM_PREP:
            begin
                if (cnt_reg == 5'd0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sgn_reg[i] <= p_reg[2*i] < p_reg[2*i+1];
                        m_reg[i]   <= (p_reg[2*i] < p_reg[2*i+1]) ?
                                      36'(p_reg[2*i+1]) - 36'(p_reg[2*i]) :
                                      36'(p_reg[2*i]) - 36'(p_reg[2*i+1]);
                    end
                    cnt_reg <= 5'd1;
                end
                else
                begin
                    degen_reg <= (mx == 36'd0);
                    if (mx != 36'd0 && mx[35:29] == 7'd0)
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] << 1;
                    else if (mx[35:30] != 6'd0)
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] >> 1;
                end
            end
            OP_SQUARE:
            begin
                sum_reg  <= sq;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 5'd0;
            end
            OP_SQRT:
            begin
                sum_reg <= sum_reg << 2;
                if (rem_sh >= 62'(trial))
                begin
                    rem_reg  <= rem_sh - 62'(trial);
                    root_reg <= {root_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[29:0], 1'b0};
                end
                cnt_reg  <= cnt_reg + 5'd1;
                lane_reg <= 2'd0;
                dcnt_reg <= 6'd0;
            end
            OP_DIV:
            begin
                if (dcnt_reg == 6'd0)
                begin
                    dnum_reg <= dsum + 46'(root_reg[30:1]);
                    dq_reg   <= '0;
                    dcnt_reg <= 6'd1;
                end
                else
                begin
                    // remainder in [45:15], numerator bits still to shift in below
                    dq_reg <= {dq_reg[12:0], dnum_reg[45] | (dtrial[31] == 1'b0)};
                    if (dnum_reg[45] | (dtrial[31] == 1'b0))
                        dnum_reg <= {dtrial[30:0], dnum_reg[13:0], 1'b0};
                    else
                        dnum_reg <= dnum_reg << 1;
                    if (dcnt_reg == 6'd15)
                    begin
                        dcnt_reg <= 6'd0;
                        lane_reg <= lane_reg + 2'd1;
                    end
                    else
                        dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd15)
                        nv_reg[lane_reg] <= sgn_reg[lane_reg] ?
                            -16'({dq_reg, dnum_reg[45] | (dtrial[31] == 1'b0)}) :
                             16'({dq_reg, dnum_reg[45] | (dtrial[31] == 1'b0)});
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_RESULT)
        begin
            o_reg[0]  <= cmd.zero_out ? 16'sd0 : signed'(prd_reg[15:0]);
            o_reg[1]  <= cmd.zero_out ? 16'sd0 : signed'(prd_reg[31:16]);
            o_reg[2]  <= cmd.zero_out ? 16'sd0 : signed'(prd_reg[47:32]);
            o_reg[3]  <= cmd.zero_out ? 16'sd0 : signed'(nrd_reg[15:0]);
            o_reg[4]  <= cmd.zero_out ? 16'sd0 : signed'(nrd_reg[31:16]);
            o_reg[5]  <= cmd.zero_out ? 16'sd0 : signed'(nrd_reg[47:32]);
            o_deg_reg <= !cmd.zero_out && c_valid_deg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg     <= 1'b0;
            func_norm_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= cmd.op == OP_RESULT;
            if (start && !busy)
                func_norm_reg <= 1'b0;
            else if (cmd.op == OP_NORM_PREP)
                func_norm_reg <= 1'b1;
        end
    end
    assign c_valid_deg = func_norm_reg && degen_reg;

    assign valid      = out_v_reg;
    assign pos_x      = o_reg[0];
    assign pos_y      = o_reg[1];
    assign pos_z      = o_reg[2];
    assign normal_x   = o_reg[3];
    assign normal_y   = o_reg[4];
    assign normal_z   = o_reg[5];
    assign degenerate = o_deg_reg;

endmodule
